### rtl/granule_time_converter_core_assert.svh
// Concurrent assertion macros used by granule_time_converter_core.sv
`ifndef GRANULE_TIME_CONVERTER_CORE_ASSERT_SVH
`define GRANULE_TIME_CONVERTER_CORE_ASSERT_SVH

// hold prop at every edge out of reset
`define GTC_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// cons in the same cycle as ante
`define GTC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// cons in the cycle after ante
`define GTC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/gtc_pkg.sv
`default_nettype none
package gtc_pkg;

	localparam int SERIAL_W        = 32;
	localparam int RATE_W          = 32;
	localparam int SHIFT_W         = 5;
	localparam int GRANULE_W       = 64;
	localparam int STATUS_W        = 2;
	localparam int SLOT_W          = 4;
	localparam int MS_PER_SEC      = 1000;
	localparam int MULBY_W         = 42;
	localparam int PROD_W          = GRANULE_W + MULBY_W;
	localparam int MUL_STEPS       = MULBY_W / 2;
	localparam int DIV_STEPS       = PROD_W / 2;
	localparam int STREAM_SLOTS_DEF = 16;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_UNKNOWN  = 2'd2,
		ST_ZERO_NUM = 2'd3
	} status_t;

	typedef struct packed {
		logic [SERIAL_W-1:0] serial;
		logic [RATE_W-1:0]   num;
		logic [RATE_W-1:0]   den;
		logic [SHIFT_W-1:0]  shift;
	} entry_t;

	typedef struct packed {
		logic              go;
		logic [RATE_W-1:0] divisor;
	} div_cmd_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quot;
		logic              rem_nz;
	} div_res_t;

endpackage
`default_nettype wire

### rtl/gtc_ram.sv
`default_nettype none
module gtc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### rtl/gtc_mul.sv
`default_nettype none
module gtc_mul
	import gtc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 go,
	input  wire logic [GRANULE_W-1:0] mag,
	input  wire logic [MULBY_W-1:0]   mulby,
	output logic                      done,
	output logic      [PROD_W-1:0]    prod
);

	localparam int CNT_W = $clog2(MUL_STEPS);

	logic                   run_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [GRANULE_W-1:0]   a1_q;
	logic [GRANULE_W+1:0]   a3_q;
	logic [GRANULE_W-1:0]   hi_q;
	logic [MULBY_W-1:0]     lo_q;
	logic [GRANULE_W+1:0]   addend;
	logic [GRANULE_W+1:0]   sum;

	always_comb begin
		case (lo_q[1:0])
			2'd0:    addend = '0;
			2'd1:    addend = (GRANULE_W+2)'(a1_q);
			2'd2:    addend = {1'b0, a1_q, 1'b0};
			2'd3:    addend = a3_q;
			default: addend = '0;
		endcase
	end

	assign sum = (GRANULE_W+2)'(hi_q) + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a1_q <= mag;
			a3_q <= (GRANULE_W+2)'(mag) + {1'b0, mag, 1'b0};
			hi_q <= '0;
			lo_q <= mulby;
		end else if (run_q) begin
			hi_q <= sum[GRANULE_W+1:2];
			lo_q <= {sum[1:0], lo_q[MULBY_W-1:2]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};

endmodule
`default_nettype wire

### rtl/gtc_div.sv
`default_nettype none
module gtc_div
	import gtc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire div_cmd_t          cmd,
	input  wire logic [PROD_W-1:0] dividend,
	output div_res_t               res
);

	localparam int CNT_W = $clog2(DIV_STEPS);
	localparam int TW    = RATE_W + 2;

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0] dvd_q;
	logic [RATE_W-1:0] rem_q;
	logic [TW-1:0]     d1_q;
	logic [TW-1:0]     d3_q;
	logic [TW-1:0]     d2;
	logic [TW-1:0]     t;
	logic [TW-1:0]     dsel;
	logic [1:0]        digit;
	logic [TW-1:0]     r;

	assign d2 = {d1_q[TW-2:0], 1'b0};
	assign t  = {rem_q, dvd_q[PROD_W-1 -: 2]};

	always_comb begin
		if (t >= d3_q) begin
			digit = 2'd3;
			dsel  = d3_q;
		end else if (t >= d2) begin
			digit = 2'd2;
			dsel  = d2;
		end else if (t >= d1_q) begin
			digit = 2'd1;
			dsel  = d1_q;
		end else begin
			digit = 2'd0;
			dsel  = '0;
		end
		r = t - dsel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			dvd_q <= dividend;
			rem_q <= '0;
			d1_q  <= TW'(cmd.divisor);
			d3_q  <= TW'(cmd.divisor) + {1'b0, cmd.divisor, 1'b0};
		end else if (run_q) begin
			rem_q <= r[RATE_W-1:0];
			dvd_q <= {dvd_q[PROD_W-3:0], digit};
		end
	end

	assign res.done   = done_q;
	assign res.quot   = dvd_q;
	assign res.rem_nz = |rem_q;

endmodule
`default_nettype wire

### rtl/granule_time_converter_core.sv
// Granule position to milliseconds converter with a table of media streams.
// Command channel: an item (mode, stream_serial, rate_num, rate_den, key_shift,
// granule) is taken on a rising edge with start high and busy low.
// Result channel: status, slot and millis are valid for the single cycle in
// which done is high; the receiver cannot stall, so each result must be taken
// in that cycle. One result follows every item.
// Register (mode 0): the result appears in the cycle after the item; busy stays
// low, so register words may be issued every cycle.
// Convert (mode 1): the table is searched one slot a cycle through the RAM
// read port, then the granule is scaled by a radix-4 shift-add multiplier
// and divided by the rate numerator in a radix-4 restoring divider. A hit
// passes through the key adjust, absolute value, multiply and divide states
// before done; an unknown serial gives done once all n registered streams
// have been read. busy is high throughout and one convert runs at a time.
// Reset empties the table at once through the fill count; no clearing pass
// runs and entries are never freed except by reset.
`default_nettype none
module granule_time_converter_core
	import gtc_pkg::*;
#(
	parameter int STREAM_SLOTS = STREAM_SLOTS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        mode,
	input  wire logic [SERIAL_W-1:0]         stream_serial,
	input  wire logic [RATE_W-1:0]           rate_num,
	input  wire logic [RATE_W-1:0]           rate_den,
	input  wire logic [SHIFT_W-1:0]          key_shift,
	input  wire logic signed [GRANULE_W-1:0] granule,
	output logic                             done,
	output logic      [STATUS_W-1:0]         status,
	output logic      [SLOT_W-1:0]           slot,
	output logic signed [GRANULE_W-1:0]      millis
);

`include "granule_time_converter_core_assert.svh"

	localparam int AW = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
	localparam int CW = $clog2(STREAM_SLOTS + 1);
	localparam int XW = (AW > SLOT_W) ? AW : SLOT_W;
	localparam logic [GRANULE_W-1:0] S64_MAX = {1'b0, {(GRANULE_W-1){1'b1}}};
	localparam logic [GRANULE_W-1:0] S64_MIN = {1'b1, {(GRANULE_W-1){1'b0}}};

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_ADJ,
		S_ABS,
		S_MUL,
		S_DIV
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          scan_q;
	logic                   pend_s1;
	logic [AW-1:0]          addr_s1;
	logic [AW-1:0]          hit_q;
	logic [SERIAL_W-1:0]    serial_q;
	logic [GRANULE_W-1:0]   g_q;
	logic [SHIFT_W-1:0]     shift_q;
	logic [RATE_W-1:0]      num_q;
	logic [RATE_W-1:0]      den_q;
	logic                   neg_q;
	logic [GRANULE_W-1:0]   mag_q;
	logic [MULBY_W-1:0]     mulby_q;
	logic                   mul_go_q;
	logic                   div_go_q;
	logic                   done_q;
	status_t                status_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [GRANULE_W-1:0]   millis_q;

	logic                   accept;
	logic                   full;
	logic                   wr_en;
	entry_t                 wr_entry;
	entry_t                 rd_entry;
	logic                   issue;
	logic                   match;
	logic [XW-1:0]          count_x;
	logic [XW-1:0]          addr_x;
	logic [GRANULE_W-1:0]   g_key;
	logic [GRANULE_W-1:0]   g_since;
	logic                   mul_done;
	logic [PROD_W-1:0]      prod;
	div_cmd_t               div_cmd;
	div_res_t               div_res;
	logic                   hi_nz;
	logic [GRANULE_W-1:0]   q64;
	logic [GRANULE_W-1:0]   sat;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q == CW'(STREAM_SLOTS));
	assign wr_en  = accept && !mode && (rate_num != '0) && !full;

	assign wr_entry.serial = stream_serial;
	assign wr_entry.num    = rate_num;
	assign wr_entry.den    = rate_den;
	assign wr_entry.shift  = key_shift;

	gtc_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (STREAM_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AW-1:0]),
		.wdata (wr_entry),
		.raddr (scan_q[AW-1:0]),
		.rdata (rd_entry)
	);

	assign issue   = (scan_q < count_q);
	assign match   = pend_s1 && (rd_entry.serial == serial_q);
	assign count_x = XW'(count_q[AW-1:0]);
	assign addr_x  = XW'(hit_q);

	assign g_key   = GRANULE_W'($signed(g_q) >>> shift_q);
	assign g_since = g_q & ~({GRANULE_W{1'b1}} << shift_q);

	gtc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go_q),
		.mag    (mag_q),
		.mulby  (mulby_q),
		.done   (mul_done),
		.prod   (prod)
	);

	assign div_cmd.go      = div_go_q;
	assign div_cmd.divisor = num_q;

	gtc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.dividend (prod),
		.res      (div_res)
	);

	assign hi_nz = |div_res.quot[PROD_W-1:GRANULE_W];
	assign q64   = div_res.quot[GRANULE_W-1:0];

	always_comb begin
		if (!neg_q) begin
			sat = (hi_nz || q64[GRANULE_W-1]) ? S64_MAX : q64;
		end else if (hi_nz) begin
			sat = S64_MIN;
		end else if (div_res.rem_nz) begin
			sat = q64[GRANULE_W-1] ? S64_MIN : ~q64;
		end else begin
			sat = (q64 > S64_MIN) ? S64_MIN : (~q64 + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			scan_q   <= '0;
			pend_s1  <= 1'b0;
			addr_s1  <= '0;
			hit_q    <= '0;
			serial_q <= '0;
			g_q      <= '0;
			shift_q  <= '0;
			num_q    <= '0;
			den_q    <= '0;
			neg_q    <= 1'b0;
			mag_q    <= '0;
			mulby_q  <= '0;
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			slot_q   <= '0;
			millis_q <= '0;
		end else begin
			done_q   <= 1'b0;
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					scan_q  <= '0;
					if (accept) begin
						serial_q <= stream_serial;
						g_q      <= granule;
						if (mode) begin
							state_q <= S_SCAN;
						end else begin
							done_q   <= 1'b1;
							millis_q <= '0;
							if (rate_num == '0) begin
								status_q <= ST_ZERO_NUM;
								slot_q   <= '0;
							end else if (full) begin
								status_q <= ST_FULL;
								slot_q   <= '0;
							end else begin
								status_q <= ST_OK;
								slot_q   <= count_x[SLOT_W-1:0];
								count_q  <= count_q + 1'b1;
							end
						end
					end
				end
				S_SCAN: begin
					pend_s1 <= issue;
					addr_s1 <= scan_q[AW-1:0];
					scan_q  <= scan_q + CW'(issue);
					if (match) begin
						hit_q   <= addr_s1;
						num_q   <= rd_entry.num;
						den_q   <= rd_entry.den;
						shift_q <= rd_entry.shift;
						state_q <= S_ADJ;
					end else if (!issue && !pend_s1) begin
						done_q   <= 1'b1;
						status_q <= ST_UNKNOWN;
						slot_q   <= '0;
						millis_q <= '0;
						state_q  <= S_IDLE;
					end
				end
				S_ADJ: begin
					g_q     <= g_key + g_since;
					state_q <= S_ABS;
				end
				S_ABS: begin
					neg_q    <= g_q[GRANULE_W-1];
					mag_q    <= g_q[GRANULE_W-1] ? (~g_q + 1'b1) : g_q;
					mulby_q  <= MULBY_W'(den_q) * MULBY_W'(MS_PER_SEC);
					mul_go_q <= 1'b1;
					state_q  <= S_MUL;
				end
				S_MUL: begin
					if (mul_done) begin
						div_go_q <= 1'b1;
						state_q  <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_res.done) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						slot_q   <= addr_x[SLOT_W-1:0];
						millis_q <= sat;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign status = status_q;
	assign slot   = slot_q;
	assign millis = millis_q;

	`GTC_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(STREAM_SLOTS), "fill count beyond table depth")
	`GTC_ASSERT_NXT(a_count_step, clk, arst_n, wr_en, count_q == CW'($past(count_q) + 1'b1), "register word did not advance fill count")
	`GTC_ASSERT_IMP(a_scan_range, clk, arst_n, state_q == S_SCAN && pend_s1, CW'(addr_s1) < count_q, "lookup read beyond filled slots")
	`GTC_ASSERT_IMP(a_err_zero, clk, arst_n, done && status != ST_OK, millis == '0 && slot == '0, "error word carries data")

endmodule
`default_nettype wire
